// ===== hdl/tach_pkg.sv =====
// ----------------------------------------------------------------------------
// tach_pkg
// Shared constants, register codes and types of the pulse period tachometer.
// ----------------------------------------------------------------------------
package tach_pkg;

   localparam int TIME_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH    = 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RUN_ENABLE         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSES_PER_CYCLE   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CYCLES_PER_CAPTURE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_US         = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_RISING     = 3'd4;

   localparam int PULSES_BITS  = 8;
   localparam int CYCLES_BITS  = 16;
   localparam int TIMEOUT_BITS = 32;
   localparam int PERIOD_BITS  = 32;
   localparam int HERTZ_BITS   = 36;
   localparam int RPM_BITS     = 42;

   localparam logic [63:0] US_PER_SECOND      = 64'd1000000;
   localparam logic [63:0] SECONDS_PER_MINUTE = 64'd60;
   localparam logic [63:0] PERIOD_MAX         = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] HERTZ_MAX          = 64'h0000_000F_FFFF_FFFF;
   localparam logic [63:0] RPM_MAX            = 64'h0000_03FF_FFFF_FFFF;

   typedef struct packed {
      logic                    run_enable;
      logic [PULSES_BITS-1:0]  pulses_per_cycle;
      logic [CYCLES_BITS-1:0]  cycles_per_capture;
      logic [TIMEOUT_BITS-1:0] timeout_us;
      logic                    trigger_rising;
   } tach_cfg_type;

   localparam tach_cfg_type CFG_RESET = '{
      run_enable:         1'b0,
      pulses_per_cycle:   8'd1,
      cycles_per_capture: 16'd1,
      timeout_us:         32'd1000000,
      trigger_rising:     1'b1
   };

endpackage

// ===== hdl/tach_req_if.sv =====
// ----------------------------------------------------------------------------
// tach_req_if
// Input channel: one pin sample and microsecond tick per item.
// ----------------------------------------------------------------------------
interface tach_req_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic tick_us;

   modport source (output valid, output pin_level, output tick_us, input ready);
   modport sink   (input valid, input pin_level, input tick_us, output ready);
endinterface

// ===== hdl/tach_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tach_rsp_if
// Result channel: period, frequency, rpm and stale flag per item.
// ----------------------------------------------------------------------------
interface tach_rsp_if;
   import tach_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [PERIOD_BITS-1:0] period_us;
   logic [HERTZ_BITS-1:0]  hertz_q16;
   logic [RPM_BITS-1:0]    rpm_q16;
   logic                   stale;

   modport source (output valid, output period_us, output hertz_q16, output rpm_q16,
                   output stale, input ready);
   modport sink   (input valid, input period_us, input hertz_q16, input rpm_q16,
                   input stale, output ready);
endinterface

// ===== hdl/tach_front.sv =====
// ----------------------------------------------------------------------------
// tach_front
// Edge detection, microsecond timebase, edge counting and timeout check.
// Emits one capture or stale job per item that causes a result.
// ----------------------------------------------------------------------------
module tach_front #(
   parameter int TIME_BITS  = tach_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = tach_pkg::COUNT_BITS_DEF,
   parameter int JOB_BITS   = tach_pkg::TIME_BITS_DEF + tach_pkg::CYCLES_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   tach_req_if.sink              req_if,
   input  tach_pkg::tach_cfg_type cfg,
   input  logic                  run_start,
   input  logic                  queue_full,
   output logic                  push_valid,
   output logic [JOB_BITS-1:0]   push_data
);
   import tach_pkg::*;

   localparam int TE_BITS   = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;
   localparam int PROD_BITS = PULSES_BITS + CYCLES_BITS;
   localparam int PE_BITS   = (PROD_BITS > COUNT_BITS) ? PROD_BITS : COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [TIME_BITS-1:0]  last_ff, last_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  level_ff, level_in;
   logic                  stale_rep_ff, stale_rep_in;

   logic                   accept;
   logic                   pin_edge;
   logic [PROD_BITS-1:0]   product;
   logic [COUNT_BITS-1:0]  target;
   logic [TIME_BITS-1:0]   time_step;
   logic [TIME_BITS-1:0]   elapsed;
   logic [COUNT_BITS-1:0]  count_step;
   logic                   capture;
   logic                   timed_out;
   logic [CYCLES_BITS-1:0] divisor;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;

   assign pin_edge = cfg.trigger_rising ? (!level_ff && req_if.pin_level)
                                        : (level_ff && !req_if.pin_level);

   assign product = PROD_BITS'(cfg.pulses_per_cycle) * PROD_BITS'(cfg.cycles_per_capture);

   always_comb begin
      if (product == '0) begin
         target = COUNT_BITS'(1);
      end else if (PE_BITS'(product) > PE_BITS'(COUNT_MAX)) begin
         target = COUNT_MAX;
      end else begin
         target = COUNT_BITS'(product);
      end
   end

   assign time_step  = req_if.tick_us ? time_ff + TIME_BITS'(1) : time_ff;
   assign elapsed    = time_step - last_ff;
   assign count_step = count_ff + COUNT_BITS'(1);
   assign capture    = pin_edge && (count_step >= target);
   assign timed_out  = !stale_rep_ff && (TE_BITS'(elapsed) > TE_BITS'(cfg.timeout_us));
   assign divisor    = (cfg.cycles_per_capture == '0) ? CYCLES_BITS'(1)
                                                      : cfg.cycles_per_capture;

   always_comb begin
      time_in      = time_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      level_in     = level_ff;
      stale_rep_in = stale_rep_ff;
      push_valid   = 1'b0;
      push_data    = {1'b0, divisor, elapsed};
      if (run_start) begin
         time_in      = '0;
         last_in      = '0;
         count_in     = '0;
         stale_rep_in = 1'b0;
      end else if (accept) begin
         level_in = req_if.pin_level;
         if (cfg.run_enable) begin
            time_in = time_step;
            if (pin_edge) begin
               count_in = count_step;
            end
            if (capture) begin
               // restart the interval at this edge
               last_in      = time_step;
               count_in     = '0;
               stale_rep_in = 1'b0;
               push_valid   = 1'b1;
            end else if (timed_out) begin
               stale_rep_in = 1'b1;
               push_valid   = 1'b1;
               push_data    = {1'b1, divisor, elapsed};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         level_ff     <= 1'b0;
         stale_rep_ff <= 1'b0;
      end else begin
         time_ff      <= time_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         level_ff     <= level_in;
         stale_rep_ff <= stale_rep_in;
      end
   end

endmodule

// ===== hdl/tach_fifo.sv =====
// ----------------------------------------------------------------------------
// tach_fifo
// Short job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module tach_fifo #(
   parameter int WIDTH = 49,
   parameter int DEPTH = tach_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/tach_back.sv =====
// ----------------------------------------------------------------------------
// tach_back
// Turns a job into a result: period, hertz and rpm through one shared
// restoring divider, one quotient bit per cycle, then an output register.
// ----------------------------------------------------------------------------
module tach_back #(
   parameter int TIME_BITS = tach_pkg::TIME_BITS_DEF,
   parameter int FRAC_BITS = tach_pkg::FRAC_BITS_DEF,
   parameter int JOB_BITS  = tach_pkg::TIME_BITS_DEF + tach_pkg::CYCLES_BITS + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  logic [JOB_BITS-1:0] job_data,
   output logic                job_pop,
   tach_rsp_if.source          rsp_if
);
   import tach_pkg::*;

   localparam int NUM_BITS  = FRAC_BITS + 33;
   localparam int DW        = (TIME_BITS > NUM_BITS) ? TIME_BITS : NUM_BITS;
   localparam int EXT_W     = (DW > RPM_BITS) ? DW : RPM_BITS;
   localparam int STEP_BITS = $clog2(DW);
   localparam logic [DW-1:0] HZ_NUM  = DW'(US_PER_SECOND << FRAC_BITS);
   localparam logic [DW-1:0] RPM_NUM = DW'((SECONDS_PER_MINUTE * US_PER_SECOND) << FRAC_BITS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PERIOD = 3'd1;
   localparam logic [2:0] ST_HERTZ  = 3'd2;
   localparam logic [2:0] ST_RPM    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [DW-1:0]          quo_ff, quo_in;
   logic [31:0]            rem_ff, rem_in;
   logic [31:0]            divisor_ff, divisor_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [HERTZ_BITS-1:0]  hertz_ff, hertz_in;
   logic [RPM_BITS-1:0]    rpm_ff, rpm_in;
   logic                   stale_ff, stale_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_BITS-1:0] rsp_period_ff, rsp_period_in;
   logic [HERTZ_BITS-1:0]  rsp_hertz_ff, rsp_hertz_in;
   logic [RPM_BITS-1:0]    rsp_rpm_ff, rsp_rpm_in;
   logic                   rsp_stale_ff, rsp_stale_in;

   logic                   job_stale;
   logic [CYCLES_BITS-1:0] job_divisor;
   logic [TIME_BITS-1:0]   job_interval;
   logic [32:0]            rem_shift;
   logic                   quo_bit;
   logic [31:0]            rem_step;
   logic [DW-1:0]          quo_step;
   logic [EXT_W-1:0]       quo_ext;
   logic                   last_step;
   logic [PERIOD_BITS-1:0] period_sat;
   logic [HERTZ_BITS-1:0]  hertz_sat;
   logic [RPM_BITS-1:0]    rpm_sat;
   logic                   out_free;

   assign job_stale    = job_data[JOB_BITS-1];
   assign job_divisor  = job_data[JOB_BITS-2 -: CYCLES_BITS];
   assign job_interval = job_data[TIME_BITS-1:0];

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, quo_ff[DW-1]};
   assign quo_bit   = (rem_shift >= 33'(divisor_ff));
   assign rem_step  = quo_bit ? 32'(rem_shift - 33'(divisor_ff)) : rem_shift[31:0];
   assign quo_step  = {quo_ff[DW-2:0], quo_bit};
   assign quo_ext   = EXT_W'(quo_step);
   assign last_step = (step_ff == STEP_BITS'(DW - 1));

   assign period_sat = (quo_ext > EXT_W'(PERIOD_MAX)) ? PERIOD_BITS'(PERIOD_MAX)
                                                      : quo_ext[PERIOD_BITS-1:0];
   assign hertz_sat  = (quo_ext > EXT_W'(HERTZ_MAX)) ? HERTZ_BITS'(HERTZ_MAX)
                                                     : quo_ext[HERTZ_BITS-1:0];
   assign rpm_sat    = (quo_ext > EXT_W'(RPM_MAX)) ? RPM_BITS'(RPM_MAX)
                                                   : quo_ext[RPM_BITS-1:0];

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign job_pop  = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      period_in     = period_ff;
      hertz_in      = hertz_ff;
      rpm_in        = rpm_ff;
      stale_in      = stale_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_period_in = rsp_period_ff;
      rsp_hertz_in  = rsp_hertz_ff;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_stale_in  = rsp_stale_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               step_in    = '0;
               rem_in     = '0;
               quo_in     = DW'(job_interval);
               divisor_in = 32'(job_divisor);
               stale_in   = job_stale;
               period_in  = '0;
               hertz_in   = '0;
               rpm_in     = '0;
               state_in   = job_stale ? ST_DONE : ST_PERIOD;
            end
         end
         ST_PERIOD, ST_HERTZ, ST_RPM: begin
            quo_in  = quo_step;
            rem_in  = rem_step;
            step_in = step_ff + STEP_BITS'(1);
            if (last_step) begin
               step_in = '0;
               rem_in  = '0;
               unique case (state_ff)
                  ST_PERIOD: begin
                     period_in = period_sat;
                     if (period_sat == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        quo_in     = HZ_NUM + DW'(period_sat >> 1);
                        divisor_in = period_sat;
                        state_in   = ST_HERTZ;
                     end
                  end
                  ST_HERTZ: begin
                     hertz_in = hertz_sat;
                     quo_in   = RPM_NUM + DW'(period_ff >> 1);
                     state_in = ST_RPM;
                  end
                  default: begin
                     rpm_in   = rpm_sat;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            // hold the result until the output register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_period_in = period_ff;
               rsp_hertz_in  = hertz_ff;
               rsp_rpm_in    = rpm_ff;
               rsp_stale_in  = stale_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      period_ff     <= period_in;
      hertz_ff      <= hertz_in;
      rpm_ff        <= rpm_in;
      stale_ff      <= stale_in;
      rsp_period_ff <= rsp_period_in;
      rsp_hertz_ff  <= rsp_hertz_in;
      rsp_rpm_ff    <= rsp_rpm_in;
      rsp_stale_ff  <= rsp_stale_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.period_us = rsp_period_ff;
   assign rsp_if.hertz_q16 = rsp_hertz_ff;
   assign rsp_if.rpm_q16   = rsp_rpm_ff;
   assign rsp_if.stale     = rsp_stale_ff;

endmodule

// ===== hdl/pulse_period_tachometer_core.sv =====
// ----------------------------------------------------------------------------
// pulse_period_tachometer_core
// Input: one item per cycle while the 4-entry job queue has room; any item
// waits while the queue is full. A stale job skips the divider and passes
// the queue and the done state to the output register. A capture job runs
// the shared one-bit-per-cycle divider, DW = max(TIME_BITS, FRAC_BITS + 33)
// bits wide, for period, hertz and rpm in turn, one job at a time.
// Reset (synchronous): registers to defaults, counters, queue and output empty.
// ----------------------------------------------------------------------------
module pulse_period_tachometer_core #(
   parameter int TIME_BITS  = tach_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = tach_pkg::COUNT_BITS_DEF,
   parameter int FRAC_BITS  = tach_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   tach_req_if.sink                            req_if,
   tach_rsp_if.source                          rsp_if,
   input  logic                                csr_wr_en,
   input  logic [tach_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tach_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tach_pkg::*;

   localparam int JOB_BITS = TIME_BITS + CYCLES_BITS + 1;

   tach_cfg_type        cfg_ff, cfg_in;
   logic                run_start;
   logic                push_valid;
   logic [JOB_BITS-1:0] push_data;
   logic                queue_full;
   logic                queue_empty;
   logic                job_pop;
   logic [JOB_BITS-1:0] job_data;

   // enabling from the disabled state restarts timing and counting
   assign run_start = csr_wr_en && (csr_index == CSR_RUN_ENABLE) && csr_wdata[0]
                      && !cfg_ff.run_enable;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RUN_ENABLE:         cfg_in.run_enable         = csr_wdata[0];
            CSR_PULSES_PER_CYCLE:   cfg_in.pulses_per_cycle   = csr_wdata[PULSES_BITS-1:0];
            CSR_CYCLES_PER_CAPTURE: cfg_in.cycles_per_capture = csr_wdata[CYCLES_BITS-1:0];
            CSR_TIMEOUT_US:         cfg_in.timeout_us         = csr_wdata[TIMEOUT_BITS-1:0];
            CSR_TRIGGER_RISING:     cfg_in.trigger_rising     = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tach_front #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .run_start  (run_start),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   tach_fifo #(
      .WIDTH (JOB_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (job_pop),
      .pop_data  (job_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   tach_back #(
      .TIME_BITS (TIME_BITS),
      .FRAC_BITS (FRAC_BITS),
      .JOB_BITS  (JOB_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .job_data    (job_data),
      .job_pop     (job_pop),
      .rsp_if      (rsp_if)
   );

endmodule

// ===== dv/pulse_period_tachometer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_period_tachometer_core_tb
// Drives pin samples and microsecond ticks into the tachometer core, tracks
// edges, time stamps and timeouts in a local copy of the block, and checks
// every period, hertz, rpm and stale item against it. Directed items cover
// disabled operation, zero and one microsecond periods, the stale flag, both
// edge kinds, zero and saturated targets and a spare register index. Random
// phases follow, each under a fresh register setting.
// ----------------------------------------------------------------------------
module pulse_period_tachometer_core_tb;
   import tach_pkg::*;

   localparam int          SETTLE_CYCLES  = 500;
   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          RANDOM_SAMPLES = 1100;
   localparam logic [31:0] COUNT_MAX      = (32'd1 << COUNT_BITS_DEF) - 32'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] period_us;
      logic [HERTZ_BITS-1:0]  hertz_q16;
      logic [RPM_BITS-1:0]    rpm_q16;
      logic                   stale;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tach_req_if req ();
   tach_rsp_if rsp ();

   pulse_period_tachometer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the block
   tach_cfg_type               cfg;
   logic [TIME_BITS_DEF-1:0]   time_now;
   logic [TIME_BITS_DEF-1:0]   last_stamp;
   logic [COUNT_BITS_DEF-1:0]  edge_count;
   logic                       last_level;
   logic                       stale_sent;

   reading_type pending_readings[$];
   int          mismatch_count  = 0;
   int          enabled_samples = 0;
   int          idle_cycles     = 0;
   bit          steady_phase    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rounded_ratio(input logic [63:0] num,
                                                 input logic [63:0] den,
                                                 input logic [63:0] limit);
      logic [63:0] q;
      if (den == 64'd0) return 64'd0;
      q = (num + den / 64'd2) / den;
      return (q > limit) ? limit : q;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // advance the local copy by one accepted item
   task automatic track_sample(input logic level, input logic tick);
      logic                     hit;
      logic [31:0]              target;
      logic [TIME_BITS_DEF-1:0] interval;
      logic [PERIOD_BITS-1:0]   period;
      logic [CYCLES_BITS-1:0]   divisor;
      reading_type              reading;
      hit = cfg.trigger_rising ? (!last_level && level) : (last_level && !level);
      last_level = level;
      if (!cfg.run_enable) return;
      if (tick) time_now = time_now + 1'b1;
      if (hit) begin
         target = 32'(cfg.pulses_per_cycle) * 32'(cfg.cycles_per_capture);
         if (target > COUNT_MAX) target = COUNT_MAX;
         if (target == 32'd0) target = 32'd1;
         edge_count = edge_count + 1'b1;
         if (32'(edge_count) >= target) begin
            interval   = time_now - last_stamp;
            last_stamp = time_now;
            edge_count = '0;
            stale_sent = 1'b0;
            divisor = (cfg.cycles_per_capture == '0) ? CYCLES_BITS'(1) : cfg.cycles_per_capture;
            period  = interval / divisor;
            reading.period_us = period;
            reading.hertz_q16 = HERTZ_BITS'(rounded_ratio(US_PER_SECOND << FRAC_BITS_DEF,
                                                          64'(period), HERTZ_MAX));
            reading.rpm_q16   = RPM_BITS'(rounded_ratio(
                                   (SECONDS_PER_MINUTE * US_PER_SECOND) << FRAC_BITS_DEF,
                                   64'(period), RPM_MAX));
            reading.stale     = 1'b0;
            pending_readings.push_back(reading);
            return;
         end
      end
      if (!stale_sent && (time_now - last_stamp) > cfg.timeout_us) begin
         stale_sent = 1'b1;
         reading    = '0;
         reading.stale = 1'b1;
         pending_readings.push_back(reading);
      end
   endtask

   task automatic send_sample(input logic level, input logic tick);
      int gap;
      gap = steady_phase ? 0 : pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.pin_level <= level;
      req.tick_us   <= tick;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (cfg.run_enable) enabled_samples++;
      track_sample(level, tick);
   endtask

   // drop valid, drain all results, then let the block go quiet
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_RUN_ENABLE: begin
            if (data[0] && !cfg.run_enable) begin
               time_now   = '0;
               last_stamp = '0;
               edge_count = '0;
               stale_sent = 1'b0;
            end
            cfg.run_enable = data[0];
         end
         CSR_PULSES_PER_CYCLE:   cfg.pulses_per_cycle   = data[PULSES_BITS-1:0];
         CSR_CYCLES_PER_CAPTURE: cfg.cycles_per_capture = data[CYCLES_BITS-1:0];
         CSR_TIMEOUT_US:         cfg.timeout_us         = data[TIMEOUT_BITS-1:0];
         CSR_TRIGGER_RISING:     cfg.trigger_rising     = data[0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pulses(input int count, input int tick_pct);
      for (int i = 0; i < count; i++) begin
         repeat ($urandom_range(1, 3)) send_sample(1'b1, $urandom_range(1, 100) <= tick_pct);
         repeat ($urandom_range(1, 3)) send_sample(1'b0, $urandom_range(1, 100) <= tick_pct);
      end
   endtask

   task automatic send_noise(input int count, input int tick_pct);
      repeat (count) send_sample(1'($urandom_range(0, 1)), $urandom_range(1, 100) <= tick_pct);
   endtask

   task automatic test_disabled_ignores();
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
   endtask

   task automatic test_capture_extremes();
      wait_idle();
      write_reg(CSR_RUN_ENABLE, 32'd1);
      send_sample(1'b1, 1'b0);   // zero interval: period and rates all zero
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b0);   // one microsecond: highest rates
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
   endtask

   task automatic test_timeout_stale();
      wait_idle();
      write_reg(CSR_TIMEOUT_US, 32'd0);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b1);   // stale already reported
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b1);
      wait_idle();
      write_reg(CSR_TIMEOUT_US, 32'hFFFF_FFFF);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
   endtask

   task automatic test_falling_edge();
      wait_idle();
      write_reg(CSR_TRIGGER_RISING, 32'hA5A5_A5A4);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b0);
   endtask

   task automatic test_zero_target();
      wait_idle();
      write_reg(CSR_PULSES_PER_CYCLE, 32'hFFFF_FF00);
      write_reg(CSR_CYCLES_PER_CAPTURE, 32'hFFFF_0000);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
   endtask

   task automatic test_spare_index();
      wait_idle();
      write_reg(CSR_SPARE, $urandom);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b1);
   endtask

   task automatic test_saturated_target();
      wait_idle();
      write_reg(CSR_PULSES_PER_CYCLE, 32'd255);
      write_reg(CSR_CYCLES_PER_CAPTURE, 32'd65535);
      write_reg(CSR_TIMEOUT_US, 32'd50);
      write_reg(CSR_TRIGGER_RISING, 32'd1);
      send_pulses(60, 80);
   endtask

   task automatic test_target_lowered();
      wait_idle();
      write_reg(CSR_PULSES_PER_CYCLE, 32'd1);
      write_reg(CSR_CYCLES_PER_CAPTURE, 32'd8);
      write_reg(CSR_TIMEOUT_US, 32'hFFFF_FFFF);
      write_reg(CSR_RUN_ENABLE, 32'd0);
      write_reg(CSR_RUN_ENABLE, 32'd1);
      send_pulses(5, 60);
      wait_idle();
      write_reg(CSR_CYCLES_PER_CAPTURE, 32'd2);
      send_pulses(3, 60);
   endtask

   task automatic test_reenable();
      wait_idle();
      write_reg(CSR_TIMEOUT_US, 32'd20);
      write_reg(CSR_RUN_ENABLE, 32'hFFFF_FFFF);   // already on: counters kept
      send_pulses(4, 70);
      wait_idle();
      write_reg(CSR_RUN_ENABLE, 32'd0);
      send_noise(12, 50);
      wait_idle();
      write_reg(CSR_RUN_ENABLE, 32'd1);
      send_pulses(6, 70);
   endtask

   task automatic test_random_phases();
      logic [31:0] data;
      int          choice;
      int          tick_pct;
      int          count;
      while (enabled_samples < RANDOM_SAMPLES) begin
         wait_idle();
         choice = $urandom_range(0, 9);
         data = (choice == 0) ? 32'd0 : (choice == 1) ? 32'd255 :
                (choice == 2) ? 32'($urandom_range(1, 255)) : 32'($urandom_range(1, 3));
         if ($urandom_range(0, 1)) data[31:PULSES_BITS] = (32 - PULSES_BITS)'($urandom);
         write_reg(CSR_PULSES_PER_CYCLE, data);
         choice = $urandom_range(0, 9);
         data = (choice == 0) ? 32'd0 : (choice == 1) ? 32'd65535 :
                (choice == 2) ? 32'($urandom_range(1, 65535)) : 32'($urandom_range(1, 4));
         if ($urandom_range(0, 1)) data[31:CYCLES_BITS] = (32 - CYCLES_BITS)'($urandom);
         write_reg(CSR_CYCLES_PER_CAPTURE, data);
         choice = $urandom_range(0, 9);
         data = (choice == 0) ? 32'd0 : (choice == 1) ? 32'hFFFF_FFFF :
                (choice == 2) ? $urandom : 32'($urandom_range(1, 40));
         write_reg(CSR_TIMEOUT_US, data);
         data = $urandom;
         write_reg(CSR_TRIGGER_RISING, data);
         choice = $urandom_range(0, 19);
         if (choice < 3) begin
            write_reg(CSR_RUN_ENABLE, 32'd0);
            write_reg(CSR_RUN_ENABLE, 32'd1);
         end else begin
            write_reg(CSR_RUN_ENABLE, (choice < 5) ? 32'd0 : 32'd1);
         end
         steady_phase = ($urandom_range(0, 3) == 0);
         tick_pct     = $urandom_range(10, 100);
         count        = $urandom_range(10, 40);
         if ($urandom_range(0, 3) == 0) send_noise(2 * count, tick_pct);
         else                           send_pulses(count, tick_pct);
      end
      steady_phase = 1'b0;
   endtask

   // result side: ready in random runs, long and short stalls
   initial begin
      int run;
      int stall;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
         stall = $urandom_range(0, 99);
         stall = (stall < 60) ? 0 : (stall < 90) ? $urandom_range(1, 3) : $urandom_range(4, 60);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_readings.size() == 0) begin
            $error("result with no item waiting: period_us %0d, stale %0b",
                   rsp.period_us, rsp.stale);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp.period_us !== want.period_us) begin
               $error("period_us: expected %0d, actual %0d", want.period_us, rsp.period_us);
               mismatch_count++;
            end
            if (rsp.hertz_q16 !== want.hertz_q16) begin
               $error("hertz_q16: expected %0d, actual %0d", want.hertz_q16, rsp.hertz_q16);
               mismatch_count++;
            end
            if (rsp.rpm_q16 !== want.rpm_q16) begin
               $error("rpm_q16: expected %0d, actual %0d", want.rpm_q16, rsp.rpm_q16);
               mismatch_count++;
            end
            if (rsp.stale !== want.stale) begin
               $error("stale: expected %0b, actual %0b", want.stale, rsp.stale);
               mismatch_count++;
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      req.valid     <= 1'b0;
      req.pin_level <= 1'b0;
      req.tick_us   <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      cfg        = CFG_RESET;
      time_now   = '0;
      last_stamp = '0;
      edge_count = '0;
      last_level = 1'b0;
      stale_sent = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      steady_phase = 1'b1;
      test_disabled_ignores();
      test_capture_extremes();
      test_timeout_stale();
      test_falling_edge();
      test_zero_target();
      test_spare_index();
      steady_phase = 1'b0;
      test_saturated_target();
      test_target_lowered();
      test_reenable();
      test_random_phases();
      wait_idle();

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== pulse_period_tachometer_core.f =====
hdl/tach_pkg.sv
hdl/tach_req_if.sv
hdl/tach_rsp_if.sv
hdl/tach_front.sv
hdl/tach_fifo.sv
hdl/tach_back.sv
hdl/pulse_period_tachometer_core.sv
dv/pulse_period_tachometer_core_tb.sv
